/* rtl/gbwe_pkg.sv */
// Shared constants and types of the gyro bias window estimator.
package gbwe_pkg;
   localparam int Window = 512;
   localparam int Axes = 3;
   localparam int IdxW = $clog2(Window);
   localparam int AxW = $clog2(Axes);
   localparam int MemW = $clog2(Window * Axes);
   localparam logic signed [31:0] DevLimit = 32'sd67108863;
   localparam logic [15:0] CntMax = 16'hFFFF;
   localparam logic [1:0] CSR_SETTLE = 2'd0;
   localparam logic [1:0] CSR_RECHECK = 2'd1;
   localparam logic [1:0] CSR_CAP = 2'd2;

   // Unsigned divide operation started by the sequencer.
   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [31:0] divisor;
   } div_req_type;
endpackage

/* rtl/gbwe_divider.sv */
// Shared radix-2 restoring divider, one quotient bit per cycle.
module gbwe_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  gbwe_pkg::div_req_type req,
   output logic                 done,
   output logic [63:0]          quotient
);
   logic [63:0] q_ff, q_in;
   logic [32:0] r_ff, r_in;
   logic [31:0] d_ff;
   logic [6:0]  n_ff, n_in;
   logic        busy_ff, busy_in;
   logic [32:0] trial;
   logic [32:0] sh;

   // Step one bit of the long division.
   always_comb begin
      sh = {r_ff[31:0], q_ff[63]};
      trial = sh - {1'b0, d_ff};
      q_in = q_ff;
      r_in = r_ff;
      n_in = n_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         if (!trial[32]) begin
            r_in = trial;
            q_in = {q_ff[62:0], 1'b1};
         end else begin
            r_in = sh;
            q_in = {q_ff[62:0], 1'b0};
         end
         n_in = n_ff - 7'd1;
         if (n_ff == 7'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         n_ff <= '0;
      end else if (req.start) begin
         busy_ff <= 1'b1;
         n_ff <= 7'd64;
         q_ff <= req.dividend;
         r_ff <= '0;
         d_ff <= req.divisor;
      end else begin
         busy_ff <= busy_in;
         n_ff <= n_in;
         q_ff <= q_in;
         r_ff <= r_in;
      end
   end

   assign done = busy_ff && (n_ff == 7'd1);
   assign quotient = q_in;
endmodule

/* rtl/gbwe_sqrt.sv */
// Iterative integer square root, two radicand bits per cycle.
module gbwe_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);
   logic [63:0] v_ff;
   logic [33:0] rem_ff, rem_in;
   logic [31:0] r_ff, r_in;
   logic [5:0]  n_ff;
   logic        busy_ff;
   logic [33:0] cur, trial;

   // Bring down two bits and try the next root bit.
   always_comb begin
      cur = {rem_ff[31:0], v_ff[63:62]};
      trial = cur - {r_ff, 2'b01};
      if (!trial[33]) begin
         rem_in = trial;
         r_in = {r_ff[30:0], 1'b1};
      end else begin
         rem_in = cur;
         r_in = {r_ff[30:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         n_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         n_ff <= 6'd32;
         v_ff <= radicand;
         rem_ff <= '0;
         r_ff <= '0;
      end else if (busy_ff) begin
         v_ff <= {v_ff[61:0], 2'b00};
         rem_ff <= rem_in;
         r_ff <= r_in;
         n_ff <= n_ff - 6'd1;
         if (n_ff == 6'd1) busy_ff <= 1'b0;
      end
   end

   assign done = busy_ff && (n_ff == 6'd1);
   assign root = r_in;
endmodule

/* rtl/gyro_bias_window_estimator.sv */
// Top level: per-axis window mean, deviation and bias lock sequencer.
//
// Input channel req_ carries one Q16.16 sample and its axis; result channel
// rsp_ returns one transaction per sample with the updated axis status.
// csr_ writes settle_count (0), recheck_reload (1), threshold_cap (2); the
// user must write them only while the block is idle, which the block does
// not enforce; csr_ready is always high. While the axis window fills, the
// shared divider forms the mean and then the square root runs, in series;
// when full, a shift forms the mean before the root. A rejected sample goes
// from the read straight to the lock step; an axis outside the range is
// answered directly from idle. The block takes one sample at a time;
// req_ready is low while a sample is in work and while a result waits in
// the output register. The next sample is accepted at the earliest in the
// cycle after the result is taken. After reset a clearing pass over all 1536
// deviation memory entries zeroes them, with req_ready low. A stalled
// receiver holds the result register; nothing is accepted until it is taken.
module gyro_bias_window_estimator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_axis_sel,
   input  logic signed [31:0] req_rate_sample,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_taken,
   output logic        rsp_window_full,
   output logic        rsp_bias_locked,
   output logic signed [31:0] rsp_bias_value,
   output logic [30:0] rsp_rate_threshold,
   output logic signed [31:0] rsp_window_mean,
   output logic [30:0] rsp_window_sigma,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   localparam int A = gbwe_pkg::Axes;
   localparam int IW = gbwe_pkg::IdxW;
   localparam int MW = gbwe_pkg::MemW;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_READ, S_SUM, S_DIV, S_MEAN, S_DEV, S_SQ, S_ROOT, S_LOCK,
      S_OUT
   } state_type;

   state_type state_ff;
   logic [15:0] settle_ff, reload_ff;
   logic [30:0] cap_ff;
   logic [IW-1:0] widx_ff [A];
   logic signed [41:0] ssum_ff [A];
   logic [63:0] qsum_ff [A];
   logic signed [31:0] mean_ff [A];
   logic [31:0] sigma_ff [A];
   logic [15:0] cnt_ff [A];
   logic [A-1:0] full_ff, lock_ff;
   logic signed [31:0] bias_ff [A];
   logic [30:0] thr_ff [A];

   logic signed [31:0] smem [A * gbwe_pkg::Window];
   logic signed [31:0] dmem [A * gbwe_pkg::Window];
   logic signed [31:0] srd_ff, drd_ff;
   logic [MW-1:0] clr_ff;

   logic [gbwe_pkg::AxW-1:0] ax_ff;
   logic signed [31:0] x_ff;
   logic [MW-1:0] pos_ff;
   logic signed [41:0] nsum_ff;
   logic neg_ff;
   logic signed [31:0] mean_n_ff, dev_ff;
   logic [63:0] nq_ff;
   logic [63:0] nq_nx;
   logic taken_ff;
   logic [63:0] prod_ff;

   gbwe_pkg::div_req_type dreq;
   logic ddone, rstart, rdone;
   logic [63:0] dquo;
   logic [31:0] rroot;

   gbwe_divider u_div (.clock(clock), .reset(reset), .req(dreq), .done(ddone),
      .quotient(dquo));
   gbwe_sqrt u_sqrt (.clock(clock), .reset(reset), .start(rstart),
      .radicand(nq_nx >> IW), .done(rdone), .root(rroot));

   logic [41:0] nabs;
   logic [IW:0] cnt1;
   logic signed [32:0] diff;
   logic [32:0] adiff;
   logic [33:0] t3;
   logic signed [32:0] dv;

   // Combinational helpers for the gate, the division operands, the deviation and the square sum.
   always_comb begin
      diff = 33'(x_ff) - 33'(mean_ff[ax_ff]);
      adiff = diff[32] ? 33'(-diff) : 33'(diff);
      t3 = 34'(sigma_ff[ax_ff]) * 34'd3;
      nabs = nsum_ff[41] ? 42'(-nsum_ff) : 42'(nsum_ff);
      cnt1 = (IW+1)'(widx_ff[ax_ff]) + 1'b1;
      dreq.start = (state_ff == S_SUM) && !full_ff[ax_ff];
      dreq.dividend = 64'(nabs);
      dreq.divisor = 32'(cnt1);
      dv = 33'(x_ff) - 33'(mean_n_ff);
      nq_nx = nq_ff - prod_ff + 64'(dev_ff) * 64'(dev_ff);
      rstart = (state_ff == S_SQ);
   end

   // Memories: sample ring and deviation ring, one port pair each.
   always_ff @(posedge clock) begin
      if (state_ff == S_READ) begin
         srd_ff <= smem[pos_ff];
         drd_ff <= dmem[pos_ff];
      end
      if (state_ff == S_SUM) smem[pos_ff] <= x_ff;
      if (state_ff == S_CLEAR) dmem[clr_ff] <= '0;
      else if (state_ff == S_SQ) dmem[pos_ff] <= dev_ff;
   end

   // Sequencer holding the per-axis state, the settings and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         settle_ff <= 16'd500;
         reload_ff <= 16'd300;
         cap_ff <= 31'd19661;
         full_ff <= '0;
         lock_ff <= '0;
         rsp_valid <= 1'b0;
         for (int i = 0; i < A; i++) begin
            widx_ff[i] <= '0; ssum_ff[i] <= '0; qsum_ff[i] <= '0;
            mean_ff[i] <= '0; sigma_ff[i] <= '0; cnt_ff[i] <= '0;
            bias_ff[i] <= '0; thr_ff[i] <= '0;
         end
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               gbwe_pkg::CSR_SETTLE: settle_ff <= csr_data[15:0];
               gbwe_pkg::CSR_RECHECK: reload_ff <= csr_data[15:0];
               gbwe_pkg::CSR_CAP: cap_ff <= csr_data[30:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == MW'(A * gbwe_pkg::Window - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req_valid) begin
                  ax_ff <= req_axis_sel;
                  x_ff <= req_rate_sample;
                  if (req_axis_sel >= 2'(A)) begin
                     taken_ff <= 1'b0;
                     rsp_taken <= 1'b0; rsp_window_full <= 1'b0;
                     rsp_bias_locked <= 1'b0; rsp_bias_value <= '0;
                     rsp_rate_threshold <= '0; rsp_window_mean <= '0;
                     rsp_window_sigma <= '0;
                     rsp_valid <= 1'b1;
                     state_ff <= S_OUT;
                  end else begin
                     pos_ff <= MW'(req_axis_sel) * MW'(gbwe_pkg::Window)
                        + MW'(widx_ff[req_axis_sel]);
                     state_ff <= S_READ;
                  end
               end
            end
            S_READ: begin
               taken_ff <= !full_ff[ax_ff] || ({1'b0, adiff} < t3);
               if (!full_ff[ax_ff] || ({1'b0, adiff} < t3)) begin
                  state_ff <= S_SUM;
                  nsum_ff <= ssum_ff[ax_ff] + 42'(x_ff);
                  if (cnt_ff[ax_ff] != gbwe_pkg::CntMax)
                     cnt_ff[ax_ff] <= cnt_ff[ax_ff] + 16'd1;
               end else begin
                  cnt_ff[ax_ff] <= '0;
                  state_ff <= S_LOCK;
               end
            end
            S_SUM: begin
               if (full_ff[ax_ff]) nsum_ff <= nsum_ff - 42'(srd_ff);
               neg_ff <= nsum_ff[41];
               state_ff <= full_ff[ax_ff] ? S_MEAN : S_DIV;
            end
            S_DIV: begin
               if (ddone) begin
                  mean_n_ff <= neg_ff ? -32'(dquo) : 32'(dquo);
                  state_ff <= S_DEV;
               end
            end
            S_MEAN: begin
               // Truncate toward zero: bias negative sums before the shift.
               mean_n_ff <= 32'((nsum_ff + (nsum_ff[41] ?
                  42'((1 << IW) - 1) : 42'd0)) >>> IW);
               state_ff <= S_DEV;
            end
            S_DEV: begin
               ssum_ff[ax_ff] <= nsum_ff;
               mean_ff[ax_ff] <= mean_n_ff;
               if (dv > 33'(gbwe_pkg::DevLimit)) dev_ff <= gbwe_pkg::DevLimit;
               else if (dv < -33'(gbwe_pkg::DevLimit)) dev_ff <= -gbwe_pkg::DevLimit;
               else dev_ff <= 32'(dv);
               prod_ff <= 64'(drd_ff) * 64'(drd_ff);
               state_ff <= S_SQ;
               nq_ff <= qsum_ff[ax_ff];
            end
            S_SQ: begin
               nq_ff <= nq_nx;
               state_ff <= S_ROOT;
            end
            S_ROOT: begin
               if (rdone) begin
                  qsum_ff[ax_ff] <= nq_ff;
                  sigma_ff[ax_ff] <= rroot;
                  widx_ff[ax_ff] <= widx_ff[ax_ff] + 1'b1;
                  state_ff <= S_LOCK;
               end
            end
            S_LOCK: begin
               // For a taken sample, lock or refresh the bias on a full window, else mark the wrap.
               if (taken_ff) begin
                  if (full_ff[ax_ff]) begin
                     if (cnt_ff[ax_ff] > settle_ff) begin
                        if (!lock_ff[ax_ff]) begin
                           bias_ff[ax_ff] <= mean_ff[ax_ff];
                           thr_ff[ax_ff] <= (t3 > 34'(cap_ff)) ? cap_ff : 31'(t3);
                           lock_ff[ax_ff] <= 1'b1;
                           cnt_ff[ax_ff] <= '0;
                        end else if (t3 < {2'b0, thr_ff[ax_ff], 1'b0} &&
                            (41'(t3) * 41'd100) > (41'(thr_ff[ax_ff]) * 41'd71)) begin
                           bias_ff[ax_ff] <= mean_ff[ax_ff];
                           cnt_ff[ax_ff] <= reload_ff;
                        end
                     end
                  end else if (widx_ff[ax_ff] == '0) begin
                     full_ff[ax_ff] <= 1'b1;
                  end
               end
               state_ff <= S_OUT;
               rsp_valid <= 1'b0;
            end
            S_OUT: begin
               if (!rsp_valid) begin
                  rsp_valid <= 1'b1;
                  rsp_taken <= taken_ff;
                  rsp_window_full <= full_ff[ax_ff];
                  rsp_bias_locked <= lock_ff[ax_ff];
                  rsp_bias_value <= bias_ff[ax_ff];
                  rsp_rate_threshold <= thr_ff[ax_ff];
                  rsp_window_mean <= mean_ff[ax_ff];
                  rsp_window_sigma <= sigma_ff[ax_ff][30:0];
               end else if (rsp_ready) begin
                  rsp_valid <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;

   a_one_job: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("accept while result pending");
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      dreq.start |-> state_ff == S_SUM) else $error("divider started out of step");
   a_lock_keep: assert property (@(posedge clock) disable iff (reset)
      (lock_ff != '0) |=> (lock_ff != '0)) else $error("lock dropped");
endmodule
